[rtl/cascade_incremental_pid_servo_top_macros.svh]
// Assertion macros for the cascaded incremental PID servo.
// Included by the RTL files that carry concurrent checks; empty under SYNTHESIS.
`ifndef CASCADE_INCREMENTAL_PID_SERVO_TOP_MACROS_SVH
`define CASCADE_INCREMENTAL_PID_SERVO_TOP_MACROS_SVH
`ifndef SYNTHESIS
// check prop at every clock edge outside reset
`define CIPID_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("cipid assertion failed");
// check prop at every clock edge, reset included
`define CIPID_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("cipid assertion failed");
`else
`define CIPID_ASSERT(lbl, clk, rst_n, prop)
`define CIPID_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/cipid_pkg.sv]
// Shared widths, types and register indexes of the cascaded incremental PID servo.
// Used by cipid_mul and cascade_incremental_pid_servo_top; depends on nothing.
package cipid_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int LIM_W     = 31;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int DIGIT_W   = 4;
	localparam int DIGITS    = DATA_W / DIGIT_W;
	localparam int CNT_W     = $clog2(DIGITS);
	localparam int PP_W      = DATA_W + DIGIT_W + 1;
	localparam int HI_W      = DATA_W + DIGIT_W + 2;
	localparam int TERM_W    = PROD_W - FRAC_BITS;
	localparam int SUM_W     = PROD_W - FRAC_BITS + 2;
	localparam int EXT_W     = DATA_W + 3;
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int ADDR_W    = REG_IDX_W + 2;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [LIM_W-1:0] limit_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_POS_KP    = reg_idx_t'(0);
	localparam reg_idx_t REG_POS_KI    = reg_idx_t'(1);
	localparam reg_idx_t REG_POS_KD    = reg_idx_t'(2);
	localparam reg_idx_t REG_POS_LIMIT = reg_idx_t'(3);
	localparam reg_idx_t REG_SPD_KP    = reg_idx_t'(4);
	localparam reg_idx_t REG_SPD_KI    = reg_idx_t'(5);
	localparam reg_idx_t REG_SPD_KD    = reg_idx_t'(6);
	localparam reg_idx_t REG_SPD_LIMIT = reg_idx_t'(7);

endpackage

[rtl/cascade_incremental_pid_servo_top.sv]
// Top level of the cascaded incremental PID servo: APB registers, loop sequencer,
// loop state and result register. Depends on cipid_pkg, cipid_mul and the macro header.
//
// One item runs one or two passes of an incremental PID loop (the angle loop, then
// the speed loop in position mode; the speed loop alone in speed mode). Each pass uses
// three 4-bit digit-serial 32x32 multipliers that form the Kp, Ki and Kd terms side
// by side. A new item is not accepted until the previous one is through, including
// any wait while the previous result still sits in the output register.
// in_stall is high while an item is in work.
`include "cascade_incremental_pid_servo_top_macros.svh"

module cascade_incremental_pid_servo_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cipid_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  cipid_pkg::word_t              target,
	input  cipid_pkg::word_t              angle_meas,
	input  cipid_pkg::word_t              speed_meas,
	output logic                          out_valid,
	input  logic                          out_stall,
	output cipid_pkg::word_t              drive,
	output cipid_pkg::word_t              speed_setpoint
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_DIFF,
		ST_MUL,
		ST_WAIT,
		ST_ADD1,
		ST_ADD2,
		ST_ADD3,
		ST_CLAMP,
		ST_OUT
	} state_t;

	function automatic cipid_pkg::word_t sat32(input logic signed [cipid_pkg::EXT_W-1:0] x);
		if (x > 35'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -35'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return x[cipid_pkg::DATA_W-1:0];
		end
	endfunction

	// configuration registers
	cipid_pkg::word_t   pos_kp_q, pos_ki_q, pos_kd_q;
	cipid_pkg::word_t   spd_kp_q, spd_ki_q, spd_kd_q;
	cipid_pkg::limit_t  pos_limit_q, spd_limit_q;

	// sequencer, loop state and result
	state_t             state_q;
	logic               outer_q;
	logic               out_valid_q;
	cipid_pkg::word_t   drive_q, setpoint_q;
	cipid_pkg::word_t   outer_acc_q, outer_e1_q, outer_e0_q;
	cipid_pkg::word_t   inner_acc_q, inner_e1_q, inner_e0_q;

	// captured item and datapath
	logic               opcode_q;
	cipid_pkg::word_t   target_q, angle_q, speed_q;
	cipid_pkg::word_t   e_q, de_q, dd_q;
	logic signed [cipid_pkg::SUM_W-1:0] sum_q;

	logic               cfg_wr;
	logic               accept;
	cipid_pkg::reg_idx_t wr_idx, rd_idx;
	cipid_pkg::word_t   ref_v, fdb_v, acc_v, e1_v, e0_v, kp_v, ki_v, kd_v;
	cipid_pkg::limit_t  lim_v;
	logic signed [cipid_pkg::EXT_W-1:0] ref_x, fdb_x, e_x, e1_x, e0_x;
	cipid_pkg::prod_t   prod_p, prod_i, prod_d;
	logic               done_p, done_i, done_d, mul_done, mul_start;
	logic signed [cipid_pkg::TERM_W-1:0] term_p, term_i, term_d;
	logic signed [cipid_pkg::SUM_W-1:0]  lim_s, clamped;
	cipid_pkg::word_t   res_v;
	logic               inner_in_range;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign wr_idx = paddr[cipid_pkg::ADDR_W-1:2];
	assign rd_idx = paddr[cipid_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_kp_q    <= '0;
			pos_ki_q    <= '0;
			pos_kd_q    <= '0;
			pos_limit_q <= '0;
			spd_kp_q    <= '0;
			spd_ki_q    <= '0;
			spd_kd_q    <= '0;
			spd_limit_q <= '0;
		end else if (cfg_wr) begin
			case (wr_idx)
				cipid_pkg::REG_POS_KP:    pos_kp_q    <= pwdata;
				cipid_pkg::REG_POS_KI:    pos_ki_q    <= pwdata;
				cipid_pkg::REG_POS_KD:    pos_kd_q    <= pwdata;
				cipid_pkg::REG_POS_LIMIT: pos_limit_q <= pwdata[cipid_pkg::LIM_W-1:0];
				cipid_pkg::REG_SPD_KP:    spd_kp_q    <= pwdata;
				cipid_pkg::REG_SPD_KI:    spd_ki_q    <= pwdata;
				cipid_pkg::REG_SPD_KD:    spd_kd_q    <= pwdata;
				cipid_pkg::REG_SPD_LIMIT: spd_limit_q <= pwdata[cipid_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (rd_idx)
			cipid_pkg::REG_POS_KP:    prdata = pos_kp_q;
			cipid_pkg::REG_POS_KI:    prdata = pos_ki_q;
			cipid_pkg::REG_POS_KD:    prdata = pos_kd_q;
			cipid_pkg::REG_POS_LIMIT: prdata = {1'b0, pos_limit_q};
			cipid_pkg::REG_SPD_KP:    prdata = spd_kp_q;
			cipid_pkg::REG_SPD_KI:    prdata = spd_ki_q;
			cipid_pkg::REG_SPD_KD:    prdata = spd_kd_q;
			cipid_pkg::REG_SPD_LIMIT: prdata = {1'b0, spd_limit_q};
			default:                  prdata = '0;
		endcase
	end

	// loop select
	assign ref_v = outer_q ? target_q : (opcode_q ? outer_acc_q : target_q);
	assign fdb_v = outer_q ? angle_q : speed_q;
	assign acc_v = outer_q ? outer_acc_q : inner_acc_q;
	assign e1_v  = outer_q ? outer_e1_q : inner_e1_q;
	assign e0_v  = outer_q ? outer_e0_q : inner_e0_q;
	assign kp_v  = outer_q ? pos_kp_q : spd_kp_q;
	assign ki_v  = outer_q ? pos_ki_q : spd_ki_q;
	assign kd_v  = outer_q ? pos_kd_q : spd_kd_q;
	assign lim_v = outer_q ? pos_limit_q : spd_limit_q;

	assign ref_x = cipid_pkg::EXT_W'(ref_v);
	assign fdb_x = cipid_pkg::EXT_W'(fdb_v);
	assign e_x   = cipid_pkg::EXT_W'(e_q);
	assign e1_x  = cipid_pkg::EXT_W'(e1_v);
	assign e0_x  = cipid_pkg::EXT_W'(e0_v);

	assign mul_start = (state_q == ST_MUL);
	assign mul_done  = done_p && done_i && done_d;

	cipid_mul u_mul_p (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (kp_v),
		.b       (de_q),
		.product (prod_p),
		.done    (done_p)
	);

	cipid_mul u_mul_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (ki_v),
		.b       (e_q),
		.product (prod_i),
		.done    (done_i)
	);

	cipid_mul u_mul_d (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (kd_v),
		.b       (dd_q),
		.product (prod_d),
		.done    (done_d)
	);

	// floor scaling is the arithmetic shift
	assign term_p = prod_p[cipid_pkg::PROD_W-1:cipid_pkg::FRAC_BITS];
	assign term_i = prod_i[cipid_pkg::PROD_W-1:cipid_pkg::FRAC_BITS];
	assign term_d = prod_d[cipid_pkg::PROD_W-1:cipid_pkg::FRAC_BITS];

	assign lim_s = cipid_pkg::SUM_W'({1'b0, lim_v});

	always_comb begin
		if (sum_q > lim_s) begin
			clamped = lim_s;
		end else if (sum_q < -lim_s) begin
			clamped = -lim_s;
		end else begin
			clamped = sum_q;
		end
	end

	assign res_v = clamped[cipid_pkg::DATA_W-1:0];

	assign accept         = in_valid && !in_stall;
	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign drive          = drive_q;
	assign speed_setpoint = setpoint_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_q <= opcode;
			target_q <= target;
			angle_q  <= angle_meas;
			speed_q  <= speed_meas;
		end
		case (state_q)
			ST_ERR: begin
				e_q <= sat32(ref_x - fdb_x);
			end
			ST_DIFF: begin
				de_q <= sat32(e_x - e1_x);
				dd_q <= sat32(e_x - (e1_x <<< 1) + e0_x);
			end
			ST_ADD1: begin
				sum_q <= cipid_pkg::SUM_W'(acc_v) + cipid_pkg::SUM_W'(term_p);
			end
			ST_ADD2: begin
				sum_q <= sum_q + cipid_pkg::SUM_W'(term_i);
			end
			ST_ADD3: begin
				sum_q <= sum_q + cipid_pkg::SUM_W'(term_d);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			outer_q     <= 1'b0;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
			setpoint_q  <= '0;
			outer_acc_q <= '0;
			outer_e1_q  <= '0;
			outer_e0_q  <= '0;
			inner_acc_q <= '0;
			inner_e1_q  <= '0;
			inner_e0_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						outer_q <= opcode;
						state_q <= ST_ERR;
					end
				end
				ST_ERR:  state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_WAIT;
				ST_WAIT: begin
					if (mul_done) begin
						state_q <= ST_ADD1;
					end
				end
				ST_ADD1: state_q <= ST_ADD2;
				ST_ADD2: state_q <= ST_ADD3;
				ST_ADD3: state_q <= ST_CLAMP;
				ST_CLAMP: begin
					if (outer_q) begin
						outer_acc_q <= res_v;
						outer_e0_q  <= outer_e1_q;
						outer_e1_q  <= e_q;
						outer_q     <= 1'b0;
						state_q     <= ST_ERR;
					end else begin
						inner_acc_q <= res_v;
						inner_e0_q  <= inner_e1_q;
						inner_e1_q  <= e_q;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					// load once the previous transfer is gone
					if (!out_valid_q || !out_stall) begin
						drive_q     <= inner_acc_q;
						setpoint_q  <= outer_acc_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign inner_in_range =
		($signed({inner_acc_q[cipid_pkg::DATA_W-1], inner_acc_q}) <= $signed({2'b00, spd_limit_q}))
		&& ($signed({inner_acc_q[cipid_pkg::DATA_W-1], inner_acc_q}) >= -$signed({2'b00, spd_limit_q}));

	`CIPID_ASSERT(a_accept_starts, clk, arst_n, accept |=> (state_q == ST_ERR))
	`CIPID_ASSERT(a_inner_clamped, clk, arst_n, (state_q == ST_CLAMP && !outer_q) |=> inner_in_range)
	`CIPID_ASSERT(a_speed_mode_outer_held, clk, arst_n, (state_q != ST_IDLE && !opcode_q) |=> $stable(outer_acc_q))
	`CIPID_ASSERT(a_result_from_out, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_OUT))

endmodule

[rtl/cipid_mul.sv]
// Digit-serial signed multiplier: one DIGIT_W-bit digit of b per cycle.
// Depends on cipid_pkg and the assertion macro header.
`include "cascade_incremental_pid_servo_top_macros.svh"

module cipid_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cipid_pkg::word_t   a,
	input  cipid_pkg::word_t   b,
	output cipid_pkg::prod_t   product,
	output logic               done
);

	logic                                busy_q;
	logic                                done_q;
	logic [cipid_pkg::CNT_W-1:0]         cnt_q;
	cipid_pkg::word_t                    a_q;
	logic [cipid_pkg::DATA_W-1:0]        b_q;
	logic signed [cipid_pkg::HI_W-1:0]   hi_q;
	logic [cipid_pkg::DATA_W-1:0]        lo_q;

	logic                                last;
	logic [cipid_pkg::DIGIT_W-1:0]       digit;
	logic signed [cipid_pkg::DIGIT_W:0]  digit_x;
	logic signed [cipid_pkg::PP_W-1:0]   pp;
	logic signed [cipid_pkg::HI_W-1:0]   sum;

	assign last    = (cnt_q == cipid_pkg::CNT_W'(cipid_pkg::DIGITS - 1));
	assign digit   = b_q[cipid_pkg::DIGIT_W-1:0];
	// top digit carries the sign weight
	assign digit_x = last ? $signed({digit[cipid_pkg::DIGIT_W-1], digit})
	                      : $signed({1'b0, digit});
	assign pp      = a_q * digit_x;
	assign sum     = hi_q + cipid_pkg::HI_W'(pp);
	assign product = {hi_q[cipid_pkg::DATA_W-1:0], lo_q};
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
		end else if (busy_q) begin
			hi_q <= sum >>> cipid_pkg::DIGIT_W;
			lo_q <= {sum[cipid_pkg::DIGIT_W-1:0], lo_q[cipid_pkg::DATA_W-1:cipid_pkg::DIGIT_W]};
			b_q  <= b_q >> cipid_pkg::DIGIT_W;
		end
	end

	`CIPID_ASSERT_ALWAYS(a_busy_not_done, clk, !(busy_q && done_q))
	`CIPID_ASSERT(a_start_when_free, clk, arst_n, start |-> !busy_q)
	`CIPID_ASSERT(a_done_pulse, clk, arst_n, done_q |=> !done_q)

endmodule
